@@ hdl/hpst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpst_pkg
// Shared types and constants for the hub port status tracker: command and
// response transfer structs, operation, feature and error codes, bit positions.
// ----------------------------------------------------------------------------
package hpst_pkg;

  // Default port storage depth
  localparam int MAX_PORTS_DEF = 15;

  // Port count after reset
  localparam logic [3:0] NUM_PORTS_RST = 4'd4;

  // Highest port number the 16-bit change bitmap can carry
  localparam int MAP_MAX_PORT = 15;

  // Operation codes
  typedef enum logic [2:0] {
    FUNC_PORT_EVENT   = 3'd0,
    FUNC_SET_RESET    = 3'd1,
    FUNC_CLEAR_CHANGE = 3'd2,
    FUNC_GET_STATUS   = 3'd3,
    FUNC_GET_BITMAP   = 3'd4
  } hpst_func_t;

  // Error codes
  localparam logic [1:0] ERR_OK           = 2'd0;
  localparam logic [1:0] ERR_INVALID_PORT = 2'd1;
  localparam logic [1:0] ERR_UNSUPPORTED  = 2'd2;

  // Highest valid change feature selector
  localparam logic [2:0] FEAT_LAST = 3'd4;

  // Speed codes from the controller
  localparam logic [3:0] SPEED_LOW  = 4'd2;
  localparam logic [3:0] SPEED_HIGH = 4'd3;

  // Status word bit positions
  localparam int ST_CONN   = 0;
  localparam int ST_ENABLE = 1;
  localparam int ST_RESET  = 4;
  localparam int ST_LOW    = 9;
  localparam int ST_HIGH   = 10;

  // Change word bit positions
  localparam int CH_CONN   = 0;
  localparam int CH_ENABLE = 1;
  localparam int CH_RESET  = 4;

  // Command transfer
  typedef struct packed {
    logic [2:0] func;
    logic [3:0] port;
    logic       connected;
    logic       enabled;
    logic [3:0] link_speed;
    logic       connect_changed;
    logic       reset_changed;
    logic [2:0] feature;
  } hpst_cmd_t;

  // Response transfer
  typedef struct packed {
    logic [10:0] status_bits;
    logic [4:0]  port_change;
    logic [15:0] change_bitmap;
    logic        notify;
    logic [1:0]  error;
  } hpst_rsp_t;

endpackage

@@ hdl/hub_port_status_tracker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hub_port_status_tracker_unit
// Per-port status and change words of an emulated root hub: controller port
// events, port reset, clear-feature, get-status and get-bitmap commands.
// ----------------------------------------------------------------------------
// One command is taken every clock cycle while busy is low; busy is high only
// during reset. A command is captured in an input register, runs through the
// port word update logic in the next cycle, and its response appears on rsp
// with done high for exactly one cycle, registered in the result register
// after the input register. The response cannot be held off, so it must be
// taken when done is high. Back-to-back commands to the same port see each
// other's updates. The port count register (cfg_wr_data, written when
// cfg_wr_en is high) may only be changed while no command is in flight.
// ----------------------------------------------------------------------------
module hub_port_status_tracker_unit #(
  parameter int MAX_PORTS = hpst_pkg::MAX_PORTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  hpst_pkg::hpst_cmd_t cmd,
  output logic                done,
  output hpst_pkg::hpst_rsp_t rsp,
  input  logic                cfg_wr_en,
  input  logic [3:0]          cfg_wr_data
);

  localparam int IDX_W     = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
  localparam int MAP_PORTS = (MAX_PORTS < hpst_pkg::MAP_MAX_PORT) ?
                             MAX_PORTS : hpst_pkg::MAP_MAX_PORT;

  // Registers
  logic                in_valid;
  hpst_pkg::hpst_cmd_t in_reg;
  logic [3:0]          port_limit;
  logic [10:0]         status_words [MAX_PORTS];
  logic [4:0]          change_words [MAX_PORTS];

  // Combinational
  logic                accept;
  logic [3:0]          ports_used;
  logic [7:0]          idx_wide;
  logic [IDX_W-1:0]    idx;
  logic                port_ok;
  logic                wr_en;
  logic [10:0]         st_new;
  logic [4:0]          ch_new;
  logic [15:0]         bitmap;
  hpst_pkg::hpst_rsp_t rsp_next;

  assign busy   = rst;
  assign accept = start && !busy;

  // Port count register
  always_ff @(posedge clk) begin
    if (rst) begin
      port_limit <= hpst_pkg::NUM_PORTS_RST;
    end else if (cfg_wr_en) begin
      port_limit <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg <= cmd;
    end
  end

  // Port decode
  always_comb begin
    if ({4'd0, port_limit} > 8'(MAX_PORTS)) begin
      ports_used = 4'(MAX_PORTS);
    end else begin
      ports_used = port_limit;
    end
    idx_wide = {4'd0, in_reg.port} - 8'd1;
    idx      = idx_wide[IDX_W-1:0];
    port_ok  = (in_reg.port != 4'd0) && (in_reg.port <= ports_used);
  end

  // Port word update
  always_comb begin
    logic [10:0] s;
    logic [4:0]  c;
    s     = status_words[idx];
    c     = change_words[idx];
    wr_en = 1'b0;
    if (in_valid && port_ok) begin
      case (in_reg.func)
        hpst_pkg::FUNC_PORT_EVENT: begin
          wr_en = 1'b1;
          if (in_reg.connect_changed) begin
            if (in_reg.connected) begin
              s[hpst_pkg::ST_CONN] = 1'b1;
            end else begin
              if (s[hpst_pkg::ST_ENABLE]) begin
                c[hpst_pkg::CH_ENABLE] = 1'b1;
              end
              s = '0;
            end
            c[hpst_pkg::CH_CONN] = 1'b1;
          end
          if (in_reg.reset_changed && in_reg.enabled) begin
            s[hpst_pkg::ST_RESET] = 1'b0;
            c[hpst_pkg::CH_RESET] = 1'b1;
            if (!s[hpst_pkg::ST_ENABLE]) begin
              s[hpst_pkg::ST_ENABLE] = 1'b1;
              c[hpst_pkg::CH_ENABLE] = 1'b1;
            end
            if (in_reg.link_speed == hpst_pkg::SPEED_LOW) begin
              s[hpst_pkg::ST_LOW] = 1'b1;
            end else if (in_reg.link_speed == hpst_pkg::SPEED_HIGH) begin
              s[hpst_pkg::ST_HIGH] = 1'b1;
            end
          end
        end
        hpst_pkg::FUNC_SET_RESET: begin
          wr_en = 1'b1;
          s[hpst_pkg::ST_RESET] = 1'b1;
          c[hpst_pkg::CH_RESET] = 1'b1;
        end
        hpst_pkg::FUNC_CLEAR_CHANGE: begin
          wr_en = 1'b1;
          if (in_reg.feature <= hpst_pkg::FEAT_LAST) begin
            c = c & ~(5'd1 << in_reg.feature);
          end
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
    st_new = s;
    ch_new = c;
  end

  // Change bitmap from the post-update change words
  always_comb begin
    bitmap = '0;
    for (int i = 0; i < MAP_PORTS; i++) begin
      if ((wr_en && (idx == IDX_W'(i))) ? (ch_new != 5'd0) : (change_words[i] != 5'd0)) begin
        bitmap[i + 1] = (4'(i + 1) <= ports_used);
      end
    end
  end

  // Response assembly
  always_comb begin
    rsp_next               = '0;
    rsp_next.change_bitmap = bitmap;
    if (in_reg.func > hpst_pkg::FUNC_GET_BITMAP) begin
      rsp_next.error = hpst_pkg::ERR_UNSUPPORTED;
    end else if (in_reg.func == hpst_pkg::FUNC_GET_BITMAP) begin
      rsp_next.notify = (bitmap != 16'd0);
    end else if (!port_ok) begin
      rsp_next.error = hpst_pkg::ERR_INVALID_PORT;
    end else begin
      rsp_next.status_bits = st_new;
      rsp_next.port_change = ch_new;
      rsp_next.notify      = (ch_new != 5'd0);
    end
  end

  // Port word storage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PORTS; i++) begin
        status_words[i] <= '0;
        change_words[i] <= '0;
      end
    end else if (wr_en) begin
      status_words[idx] <= st_new;
      change_words[idx] <= ch_new;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      rsp <= rsp_next;
    end
  end

  // Assertions
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid |=> done)
    else $error("accepted command produced no response");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_valid))
    else $error("response without a command");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.error != hpst_pkg::ERR_OK)) |->
      ((rsp.status_bits == 11'd0) && (rsp.port_change == 5'd0) && !rsp.notify))
    else $error("error response carries port data");

  a_hub_bit_clear: assert property (@(posedge clk) disable iff (rst)
    done |-> !rsp.change_bitmap[0])
    else $error("hub bit set in change bitmap");

  a_notify_change: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.port_change != 5'd0)) |-> rsp.notify)
    else $error("pending change without notify");

endmodule

@@ verif/hub_port_status_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hub_port_status_checker
// Watches the command, response and port count channels of the hub port
// status tracker, keeps its own copy of the per-port status and change words,
// works out the response of each accepted command and compares every response
// field by field, in order. Counts failures and responses still in flight.
// ----------------------------------------------------------------------------
module hub_port_status_checker #(
  parameter int MAX_PORTS = hpst_pkg::MAX_PORTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  hpst_pkg::hpst_cmd_t cmd,
  input  logic                done,
  input  hpst_pkg::hpst_rsp_t rsp,
  input  logic                cfg_wr_en,
  input  logic [3:0]          cfg_wr_data,
  output int                  fail_count,
  output int                  in_flight
);

  // Shadow copy of the port words and the port count
  logic [10:0] status_shadow [MAX_PORTS];
  logic [4:0]  change_shadow [MAX_PORTS];
  logic [3:0]  limit_shadow;

  // Responses owed by the block, oldest first
  hpst_pkg::hpst_rsp_t owed_rsp [$];

  function automatic int active_ports();
    return (int'(limit_shadow) > MAX_PORTS) ? MAX_PORTS : int'(limit_shadow);
  endfunction

  // Bit n set when port n has any change bit; bit 0 is the hub and stays clear
  function automatic logic [15:0] change_map();
    logic [15:0] map;
    map = '0;
    for (int i = 0; i < active_ports() && i < hpst_pkg::MAP_MAX_PORT; i++) begin
      if (change_shadow[i] != '0) map[i + 1] = 1'b1;
    end
    return map;
  endfunction

  // Applies one command to the shadow words and returns its response
  function automatic hpst_pkg::hpst_rsp_t advance_port_words(hpst_pkg::hpst_cmd_t c);
    hpst_pkg::hpst_rsp_t r;
    logic [10:0]         s;
    logic [4:0]          w;
    int                  k;
    r = '0;
    if (c.func > hpst_pkg::FUNC_GET_BITMAP) begin
      r.error = hpst_pkg::ERR_UNSUPPORTED;
    end else if (c.func == hpst_pkg::FUNC_GET_BITMAP) begin
      r.notify = (change_map() != '0);
    end else if (c.port == '0 || int'(c.port) > active_ports()) begin
      r.error = hpst_pkg::ERR_INVALID_PORT;
    end else begin
      k = int'(c.port) - 1;
      s = status_shadow[k];
      w = change_shadow[k];
      case (c.func)
        hpst_pkg::FUNC_PORT_EVENT: begin
          // connect change first, then reset completion
          if (c.connect_changed) begin
            if (c.connected) begin
              s[hpst_pkg::ST_CONN] = 1'b1;
            end else begin
              if (s[hpst_pkg::ST_ENABLE]) w[hpst_pkg::CH_ENABLE] = 1'b1;
              s = '0;
            end
            w[hpst_pkg::CH_CONN] = 1'b1;
          end
          if (c.reset_changed && c.enabled) begin
            s[hpst_pkg::ST_RESET] = 1'b0;
            w[hpst_pkg::CH_RESET] = 1'b1;
            if (!s[hpst_pkg::ST_ENABLE]) begin
              s[hpst_pkg::ST_ENABLE] = 1'b1;
              w[hpst_pkg::CH_ENABLE] = 1'b1;
            end
            if (c.link_speed == hpst_pkg::SPEED_LOW) s[hpst_pkg::ST_LOW] = 1'b1;
            else if (c.link_speed == hpst_pkg::SPEED_HIGH) s[hpst_pkg::ST_HIGH] = 1'b1;
          end
        end
        hpst_pkg::FUNC_SET_RESET: begin
          s[hpst_pkg::ST_RESET] = 1'b1;
          w[hpst_pkg::CH_RESET] = 1'b1;
        end
        hpst_pkg::FUNC_CLEAR_CHANGE: begin
          // unknown selectors clear nothing
          if (c.feature <= hpst_pkg::FEAT_LAST) w[c.feature] = 1'b0;
        end
        default: ;
      endcase
      status_shadow[k] = s;
      change_shadow[k] = w;
      r.status_bits = s;
      r.port_change = w;
      r.notify      = (w != '0);
    end
    r.change_bitmap = change_map();
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    hpst_pkg::hpst_rsp_t want;
    if (rst) begin
      limit_shadow = hpst_pkg::NUM_PORTS_RST;
      for (int i = 0; i < MAX_PORTS; i++) begin
        status_shadow[i] = '0;
        change_shadow[i] = '0;
      end
      owed_rsp.delete();
      fail_count = 0;
    end else begin
      // port count write comes before any command it could affect
      if (cfg_wr_en) limit_shadow = cfg_wr_data;
      if (start && !busy) owed_rsp.push_back(advance_port_words(cmd));
      if (done) begin
        if (owed_rsp.size() == 0) begin
          $display("%0t ns: response with none expected, got 0x%0h", $time, rsp);
          fail_count++;
        end else begin
          want = owed_rsp.pop_front();
          check_field("status_bits", want.status_bits, rsp.status_bits);
          check_field("port_change", want.port_change, rsp.port_change);
          check_field("change_bitmap", want.change_bitmap, rsp.change_bitmap);
          check_field("notify", want.notify, rsp.notify);
          check_field("error", want.error, rsp.error);
        end
      end
    end
    in_flight <= owed_rsp.size();
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the hub port status tracker with a short directed set of commands,
// then phases of random commands and port bring-up sequences under several
// port counts and sender idle rates. The checker beside the block predicts
// and compares each response; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 125;
  localparam int SETTLE_CYCLES  = 2000;

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  hpst_pkg::hpst_cmd_t cmd;
  logic                done;
  hpst_pkg::hpst_rsp_t rsp;
  logic                cfg_wr_en;
  logic [3:0]          cfg_wr_data;
  int                  fail_count;
  int                  in_flight;

  int         idle_pct;
  int         cur_ports;
  int         sent;

  // Port count and sender idle rate per phase; a count of zero picks one at random
  int phase_ports [PHASES] = '{15, 1, 9, 15, 0, 4};
  int phase_idle  [PHASES] = '{0, 50, 14, 50, 0, 14};

  hub_port_status_tracker_unit dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  hub_port_status_checker status_chk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .in_flight   (in_flight)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic hpst_pkg::hpst_cmd_t cmd_of(logic [2:0] f, logic [3:0] p, logic cn,
                                                 logic en, logic [3:0] sp, logic cc,
                                                 logic rc, logic [2:0] ft);
    hpst_pkg::hpst_cmd_t c;
    c.func            = f;
    c.port            = p;
    c.connected       = cn;
    c.enabled         = en;
    c.link_speed      = sp;
    c.connect_changed = cc;
    c.reset_changed   = rc;
    c.feature         = ft;
    return c;
  endfunction

  // Mostly a port in range, now and then any port number
  function automatic logic [3:0] pick_port();
    if ($urandom_range(0, 99) < 85) return 4'($urandom_range(1, cur_ports));
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [3:0] pick_speed();
    case ($urandom_range(0, 3))
      0: return hpst_pkg::SPEED_LOW;
      1: return hpst_pkg::SPEED_HIGH;
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [2:0] pick_feature();
    if ($urandom_range(0, 99) < 85) return 3'($urandom_range(0, int'(hpst_pkg::FEAT_LAST)));
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic hpst_pkg::hpst_cmd_t random_cmd();
    hpst_pkg::hpst_cmd_t c;
    int                  r;
    r = $urandom_range(0, 99);
    c = cmd_of(hpst_pkg::FUNC_PORT_EVENT, pick_port(), 1'($urandom), 1'($urandom),
               pick_speed(), 1'($urandom), 1'($urandom), pick_feature());
    if (r < 35)      c.func = hpst_pkg::FUNC_PORT_EVENT;
    else if (r < 48) c.func = hpst_pkg::FUNC_SET_RESET;
    else if (r < 68) c.func = hpst_pkg::FUNC_CLEAR_CHANGE;
    else if (r < 82) c.func = hpst_pkg::FUNC_GET_STATUS;
    else if (r < 94) c.func = hpst_pkg::FUNC_GET_BITMAP;
    else             c.func = 3'(hpst_pkg::FUNC_GET_BITMAP) + 3'($urandom_range(1, 3));
    return c;
  endfunction

  // One command transfer, then sometimes a random sender gap
  task automatic issue(hpst_pkg::hpst_cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    sent++;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Hold off until every owed response has come, then allow for the pipeline
  task automatic settle();
    int guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk);
    while (in_flight != 0 && guard < SETTLE_CYCLES) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_port_count(int n);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 4'(n);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_ports = n;
  endtask

  // Connect, reset, reset completion, status read, change clears and at times a disconnect and bitmap read on one port
  task automatic port_bringup();
    logic [3:0] p;
    p = pick_port();
    issue(cmd_of(hpst_pkg::FUNC_PORT_EVENT, p, 1'b1, 1'($urandom), pick_speed(), 1'b1,
                 1'($urandom_range(0, 3) == 0), pick_feature()));
    issue(cmd_of(hpst_pkg::FUNC_SET_RESET, p, 1'($urandom), 1'($urandom), pick_speed(),
                 1'($urandom), 1'($urandom), pick_feature()));
    issue(cmd_of(hpst_pkg::FUNC_PORT_EVENT, p, 1'($urandom), ($urandom_range(0, 7) != 0),
                 pick_speed(), ($urandom_range(0, 5) == 0), 1'b1, pick_feature()));
    issue(cmd_of(hpst_pkg::FUNC_GET_STATUS, p, 1'($urandom), 1'($urandom), pick_speed(),
                 1'($urandom), 1'($urandom), pick_feature()));
    repeat ($urandom_range(0, 3))
      issue(cmd_of(hpst_pkg::FUNC_CLEAR_CHANGE, p, 1'($urandom), 1'($urandom), pick_speed(),
                   1'($urandom), 1'($urandom), pick_feature()));
    if ($urandom_range(0, 2) == 0)
      issue(cmd_of(hpst_pkg::FUNC_PORT_EVENT, p, 1'b0, 1'($urandom), pick_speed(), 1'b1,
                   1'($urandom), pick_feature()));
    if ($urandom_range(0, 1) == 0)
      issue(cmd_of(hpst_pkg::FUNC_GET_BITMAP, p, 1'($urandom), 1'($urandom), pick_speed(),
                   1'($urandom), 1'($urandom), pick_feature()));
  endtask

  initial begin
    int target;
    rst         = 1'b1;
    start       = 1'b0;
    cmd         = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    idle_pct    = 0;
    cur_ports   = int'(hpst_pkg::NUM_PORTS_RST);
    sent        = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty hub, bad ports and funcs, connect/reset/speed cases, clears
    issue(cmd_of(hpst_pkg::FUNC_GET_BITMAP, 4'h0, 1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 3'h0));
    issue(cmd_of(hpst_pkg::FUNC_GET_STATUS, 4'h0, 1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 3'h0));
    issue(cmd_of(hpst_pkg::FUNC_GET_STATUS, 4'h5, 1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 3'h0));
    issue(cmd_of(hpst_pkg::FUNC_PORT_EVENT, 4'hF, 1'b1, 1'b1, hpst_pkg::SPEED_HIGH,
                 1'b1, 1'b1, 3'h0));
    issue(cmd_of(3'(hpst_pkg::FUNC_GET_BITMAP) + 3'd1, 4'h1, 1'b0, 1'b0, 4'h0,
                 1'b0, 1'b0, 3'h0));
    issue(cmd_of(3'h7, 4'h1, 1'b1, 1'b1, 4'hF, 1'b1, 1'b1, 3'h7));
    issue(cmd_of(hpst_pkg::FUNC_PORT_EVENT, 4'h1, 1'b1, 1'b0, 4'h0, 1'b1, 1'b0, 3'h0));
    issue(cmd_of(hpst_pkg::FUNC_SET_RESET, 4'h1, 1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 3'h0));
    issue(cmd_of(hpst_pkg::FUNC_PORT_EVENT, 4'h1, 1'b1, 1'b1, hpst_pkg::SPEED_HIGH,
                 1'b0, 1'b1, 3'h0));
    issue(cmd_of(hpst_pkg::FUNC_PORT_EVENT, 4'h2, 1'b1, 1'b1, hpst_pkg::SPEED_LOW,
                 1'b1, 1'b1, 3'h0));
    issue(cmd_of(hpst_pkg::FUNC_PORT_EVENT, 4'h2, 1'b1, 1'b0, hpst_pkg::SPEED_HIGH,
                 1'b0, 1'b1, 3'h0));
    issue(cmd_of(hpst_pkg::FUNC_PORT_EVENT, 4'h3, 1'b1, 1'b1, 4'hF, 1'b1, 1'b1, 3'h0));
    issue(cmd_of(hpst_pkg::FUNC_PORT_EVENT, 4'h1, 1'b0, 1'b0, 4'h0, 1'b1, 1'b0, 3'h0));
    issue(cmd_of(hpst_pkg::FUNC_GET_BITMAP, 4'hF, 1'b1, 1'b1, 4'hF, 1'b1, 1'b1, 3'h7));
    for (int f = 0; f < 8; f++)
      issue(cmd_of(hpst_pkg::FUNC_CLEAR_CHANGE, 4'h1, 1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 3'(f)));
    issue(cmd_of(hpst_pkg::FUNC_PORT_EVENT, 4'h4, 1'b0, 1'b1, hpst_pkg::SPEED_LOW,
                 1'b0, 1'b0, 3'h0));
    issue(cmd_of(hpst_pkg::FUNC_GET_STATUS, 4'h4, 1'b1, 1'b1, 4'hF, 1'b1, 1'b1, 3'h7));
    issue(cmd_of(hpst_pkg::FUNC_GET_STATUS, 4'h2, 1'b0, 1'b0, 4'h0, 1'b0, 1'b0, 3'h0));

    // Random phases, each under its own port count and idle rate
    for (int ph = 0; ph < PHASES; ph++) begin
      write_port_count(phase_ports[ph] != 0 ? phase_ports[ph] : $urandom_range(1, 15));
      idle_pct = phase_idle[ph];
      target = sent + PHASE_ITEMS;
      while (sent < target) begin
        if ($urandom_range(0, 99) < 55) port_bringup();
        else issue(random_cmd());
        if ($urandom_range(0, 149) == 0) settle();
      end
    end

    settle();
    if (fail_count == 0 && in_flight == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
